// File: hw/rtl/mfa_pkg.sv
// Shared types, constants and helpers for the mixed fraction ALU.
// Used by mfa_ctrl, mfa_dp and mixed_fraction_alu; no dependencies.
`default_nettype none
package mfa_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int VW = 64;   // signed value width
  localparam int MW = 63;   // magnitude width
  localparam int CW = 6;    // iteration counter width, holds MW
  localparam int RW = 32;   // result whole/num width
  localparam int DW = 31;   // result denominator width

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_NEG   = 3'd4,
    OP_CMP   = 3'd5,
    OP_TRUNC = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ORD_LESS    = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_GREATER = 2'd2
  } order_t;

  typedef enum logic [3:0] {
    U_AV    = 4'd0,
    U_BV    = 4'd1,
    U_X     = 4'd2,
    U_Y     = 4'd3,
    U_DD    = 4'd4,
    U_NMUL  = 4'd5,
    U_DDIV  = 4'd6,
    U_ADDS  = 4'd7,
    U_NEG   = 4'd8,
    U_NORM  = 4'd9,
    U_GCD   = 4'd10,
    U_QDIV  = 4'd11,
    U_RDIV  = 4'd12,
    U_DRED  = 4'd13,
    U_TRUNC = 4'd14,
    U_FIN   = 4'd15
  } uop_t;

  typedef struct packed {
    logic load;
    logic start;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic done;
    logic ovf;
    logic dzero;
    logic nzero;
    logic adzero;
  } sts_t;

  function automatic logic [MW-1:0] mag(input logic [VW-1:0] v);
    logic [VW-1:0] t;
    t = v[VW-1] ? (~v + 1'b1) : v;
    return t[MW-1:0];
  endfunction

  // true when |v| <= 2^63-1
  function automatic logic fits(input logic [VW:0] v);
    return (v[VW:VW-1] == 2'b00) || ((v[VW:VW-1] == 2'b11) && (v[VW-2:0] != '0));
  endfunction

  // whole part fits 32-bit signed
  function automatic logic w_fits(input logic [MW-1:0] q, input logic neg);
    if (neg) begin
      return (q[MW-1:RW] == '0) && (!q[RW-1] || (q[RW-2:0] == '0));
    end
    return q[MW-1:RW-1] == '0;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mfa_ctrl.sv
// Sequencer for the mixed fraction ALU: steps the datapath through micro-operations.
// Depends on mfa_pkg.
`default_nettype none
module mfa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire mfa_pkg::sts_t sts,
  output mfa_pkg::cmd_t      cmd,
  output logic               busy
);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_AV    = 17'h00002,
    S_BV    = 17'h00004,
    S_X     = 17'h00008,
    S_Y     = 17'h00010,
    S_DD    = 17'h00020,
    S_NMUL  = 17'h00040,
    S_DDIV  = 17'h00080,
    S_ADDS  = 17'h00100,
    S_NEG   = 17'h00200,
    S_NORM  = 17'h00400,
    S_GCD   = 17'h00800,
    S_QDIV  = 17'h01000,
    S_RDIV  = 17'h02000,
    S_DRED  = 17'h04000,
    S_TRUNC = 17'h08000,
    S_FIN   = 17'h10000
  } state_t;

  state_t state_r, state_nxt, after;
  logic   go_r, go_nxt;

  always_comb begin
    case (state_r)
      S_AV: after = S_BV;
      S_BV: begin
        case (sts.op)
          mfa_pkg::OP_ADD, mfa_pkg::OP_SUB, mfa_pkg::OP_CMP, mfa_pkg::OP_DIV: after = S_X;
          mfa_pkg::OP_MUL:   after = S_NMUL;
          mfa_pkg::OP_NEG:   after = S_NEG;
          mfa_pkg::OP_TRUNC: after = sts.adzero ? S_FIN : S_TRUNC;
          default:           after = S_FIN;
        endcase
      end
      S_X:     after = (sts.op == mfa_pkg::OP_DIV) ? S_DDIV : S_Y;
      S_Y:     after = (sts.op == mfa_pkg::OP_CMP) ? S_FIN : S_DD;
      S_DD:    after = S_ADDS;
      S_NMUL:  after = S_DD;
      S_DDIV:  after = S_ADDS;
      S_ADDS:  after = S_NORM;
      S_NEG:   after = S_NORM;
      S_NORM:  after = (sts.dzero || sts.nzero) ? S_FIN : S_GCD;
      S_GCD:   after = S_QDIV;
      S_QDIV:  after = S_RDIV;
      S_RDIV:  after = S_DRED;
      S_DRED:  after = S_FIN;
      S_TRUNC: after = S_FIN;
      default: after = S_IDLE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    go_nxt    = 1'b0;
    if (state_r == S_IDLE) begin
      if (start) begin
        state_nxt = S_AV;
        go_nxt    = 1'b1;
      end
    end else if (sts.done && !go_r) begin
      state_nxt = (sts.ovf && (state_r != S_FIN)) ? S_FIN : after;
      go_nxt    = (state_nxt != S_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
    end
  end

  always_comb begin
    cmd.load  = (state_r == S_IDLE) && start;
    cmd.start = go_r;
    case (state_r)
      S_AV:    cmd.uop = mfa_pkg::U_AV;
      S_BV:    cmd.uop = mfa_pkg::U_BV;
      S_X:     cmd.uop = mfa_pkg::U_X;
      S_Y:     cmd.uop = mfa_pkg::U_Y;
      S_DD:    cmd.uop = mfa_pkg::U_DD;
      S_NMUL:  cmd.uop = mfa_pkg::U_NMUL;
      S_DDIV:  cmd.uop = mfa_pkg::U_DDIV;
      S_ADDS:  cmd.uop = mfa_pkg::U_ADDS;
      S_NEG:   cmd.uop = mfa_pkg::U_NEG;
      S_NORM:  cmd.uop = mfa_pkg::U_NORM;
      S_GCD:   cmd.uop = mfa_pkg::U_GCD;
      S_QDIV:  cmd.uop = mfa_pkg::U_QDIV;
      S_RDIV:  cmd.uop = mfa_pkg::U_RDIV;
      S_DRED:  cmd.uop = mfa_pkg::U_DRED;
      S_TRUNC: cmd.uop = mfa_pkg::U_TRUNC;
      default: cmd.uop = mfa_pkg::U_FIN;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

// File: hw/rtl/mfa_dp.sv
// Datapath of the mixed fraction ALU: operand registers, serial multiplier,
// restoring divider, binary GCD and result formatting. Depends on mfa_pkg.
`default_nettype none
module mfa_dp #(
  parameter int OPERAND_WIDTH = mfa_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mfa_pkg::cmd_t            cmd,
  input  wire logic [2:0]               in_operation,
  input  wire logic [OPERAND_WIDTH-1:0] in_a_whole,
  input  wire logic [OPERAND_WIDTH-1:0] in_a_num,
  input  wire logic [OPERAND_WIDTH-2:0] in_a_den,
  input  wire logic [OPERAND_WIDTH-1:0] in_b_whole,
  input  wire logic [OPERAND_WIDTH-1:0] in_b_num,
  input  wire logic [OPERAND_WIDTH-2:0] in_b_den,
  output mfa_pkg::sts_t                 sts,
  output logic                          out_valid,
  output logic [mfa_pkg::RW-1:0]        out_res_whole,
  output logic [mfa_pkg::RW-1:0]        out_res_num,
  output logic [mfa_pkg::DW-1:0]        out_res_den,
  output logic [1:0]                    out_order,
  output logic                          out_error
);

  localparam int W  = OPERAND_WIDTH;
  localparam int VW = mfa_pkg::VW;
  localparam int MW = mfa_pkg::MW;
  localparam int CW = mfa_pkg::CW;
  localparam int RW = mfa_pkg::RW;
  localparam int DW = mfa_pkg::DW;

  typedef enum logic [3:0] {
    E_IDLE = 4'b0001,
    E_MUL  = 4'b0010,
    E_DIV  = 4'b0100,
    E_GCD  = 4'b1000
  } eng_t;

  eng_t          eng_r;
  mfa_pkg::op_t  op_r;
  mfa_pkg::uop_t uop_r;
  logic          done_r, ovf_r, dzero_r, nzero_r, out_valid_r;

  logic [VW-1:0] aw_r, an_r, ad_r, bw_r, bn_r, bd_r;
  logic [VW-1:0] av_r, bv_r, x_r, y_r, n_r, d_r;
  logic [MW-1:0] g_r, q_r, rm_r, rr_r, dr_r;

  logic [MW-1:0] mul_acc_r, mul_mp_r;
  logic [MW:0]   mul_mc_r;
  logic          mul_neg_r;
  logic [MW-1:0] dv_r, ds_r, drm_r, dq_r;
  logic [CW-1:0] cnt_r, gk_r;
  logic [MW-1:0] gu_r, gv_r;

  logic [RW-1:0] res_whole_r, res_num_r;
  logic [DW-1:0] res_den_r;
  logic [1:0]    order_r;
  logic          error_r;

  // operand selection
  logic [VW-1:0] sel_a, sel_b;
  logic [MW-1:0] dvd_sel, dvs_sel;

  always_comb begin
    case (cmd.uop)
      mfa_pkg::U_AV:   begin sel_a = aw_r; sel_b = ad_r; end
      mfa_pkg::U_BV:   begin sel_a = bw_r; sel_b = bd_r; end
      mfa_pkg::U_X:    begin sel_a = av_r; sel_b = bd_r; end
      mfa_pkg::U_Y:    begin sel_a = bv_r; sel_b = ad_r; end
      mfa_pkg::U_DD:   begin sel_a = ad_r; sel_b = bd_r; end
      mfa_pkg::U_NMUL: begin sel_a = av_r; sel_b = bv_r; end
      mfa_pkg::U_DDIV: begin sel_a = ad_r; sel_b = bv_r; end
      default:         begin sel_a = '0;   sel_b = '0;   end
    endcase
    case (cmd.uop)
      mfa_pkg::U_QDIV:  begin dvd_sel = mfa_pkg::mag(n_r);  dvs_sel = d_r[MW-1:0];  end
      mfa_pkg::U_RDIV:  begin dvd_sel = rm_r;               dvs_sel = g_r;          end
      mfa_pkg::U_DRED:  begin dvd_sel = d_r[MW-1:0];        dvs_sel = g_r;          end
      mfa_pkg::U_TRUNC: begin dvd_sel = mfa_pkg::mag(av_r); dvs_sel = ad_r[MW-1:0]; end
      default:          begin dvd_sel = '0;                 dvs_sel = '0;           end
    endcase
  end

  // serial multiplier step, LSB first
  logic [MW:0]   mul_sum, mul_mc_sh;
  logic [MW-1:0] mul_mp_sh;
  logic          mul_step_ovf;
  logic [VW-1:0] mul_p, mul_add;
  logic [VW:0]   mul_fin;

  always_comb begin
    mul_sum      = {1'b0, mul_acc_r} + (mul_mp_r[0] ? mul_mc_r : '0);
    mul_mc_sh    = {mul_mc_r[MW-1:0], 1'b0};
    mul_mp_sh    = mul_mp_r >> 1;
    mul_step_ovf = mul_sum[MW] || ((mul_mp_sh != '0) && mul_mc_sh[MW]);
    mul_p        = mul_neg_r ? (~{1'b0, mul_acc_r} + 1'b1) : {1'b0, mul_acc_r};
    case (uop_r)
      mfa_pkg::U_AV: mul_add = an_r;
      mfa_pkg::U_BV: mul_add = bn_r;
      default:       mul_add = '0;
    endcase
    mul_fin = {mul_p[VW-1], mul_p} + {mul_add[VW-1], mul_add};
  end

  // restoring divider step
  logic [MW:0]   div_trial;
  logic          div_ge;
  logic [MW-1:0] div_rm_nxt, div_q_nxt;

  always_comb begin
    div_trial  = {drm_r, dv_r[MW-1]};
    div_ge     = div_trial >= {1'b0, ds_r};
    div_rm_nxt = div_ge ? (div_trial[MW-1:0] - ds_r) : div_trial[MW-1:0];
    div_q_nxt  = {dq_r[MW-2:0], div_ge};
  end

  // add / subtract
  logic [VW:0] adds;

  always_comb begin
    case (op_r)
      mfa_pkg::OP_ADD: adds = {x_r[VW-1], x_r} + {y_r[VW-1], y_r};
      mfa_pkg::OP_SUB: adds = {x_r[VW-1], x_r} - {y_r[VW-1], y_r};
      default:         adds = {x_r[VW-1], x_r};
    endcase
  end

  // result formatting
  logic          fin_err, fin_neg;
  logic [RW-1:0] fin_whole, fin_num;
  logic [DW-1:0] fin_den;
  logic [1:0]    fin_ord;

  always_comb begin
    fin_err   = 1'b0;
    fin_neg   = 1'b0;
    fin_whole = '0;
    fin_num   = '0;
    fin_den   = DW'(1);
    fin_ord   = mfa_pkg::ORD_LESS;
    case (op_r)
      mfa_pkg::OP_ADD, mfa_pkg::OP_SUB, mfa_pkg::OP_MUL, mfa_pkg::OP_DIV,
      mfa_pkg::OP_NEG: begin
        fin_neg = n_r[VW-1];
        if (ovf_r || dzero_r) begin
          fin_err = 1'b1;
        end else if (!nzero_r) begin
          fin_err   = !mfa_pkg::w_fits(q_r, fin_neg) || (dr_r[MW-1:DW] != '0);
          fin_whole = fin_neg ? (~q_r[RW-1:0] + 1'b1) : q_r[RW-1:0];
          fin_num   = fin_neg ? (~rr_r[RW-1:0] + 1'b1) : rr_r[RW-1:0];
          fin_den   = dr_r[DW-1:0];
        end
      end
      mfa_pkg::OP_CMP: begin
        if (ovf_r) begin
          fin_err = 1'b1;
        end else if ($signed(x_r) < $signed(y_r)) begin
          fin_ord = mfa_pkg::ORD_LESS;
        end else if (x_r == y_r) begin
          fin_ord = mfa_pkg::ORD_EQUAL;
        end else begin
          fin_ord = mfa_pkg::ORD_GREATER;
        end
      end
      mfa_pkg::OP_TRUNC: begin
        fin_neg = av_r[VW-1];
        if (ovf_r || (ad_r == '0)) begin
          fin_err = 1'b1;
        end else begin
          fin_err   = !mfa_pkg::w_fits(q_r, fin_neg);
          fin_whole = fin_neg ? (~q_r[RW-1:0] + 1'b1) : q_r[RW-1:0];
        end
      end
      default: fin_err = 1'b1;
    endcase
    if (fin_err) begin
      fin_whole = '0;
      fin_num   = '0;
      fin_den   = DW'(1);
      fin_ord   = mfa_pkg::ORD_LESS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eng_r       <= E_IDLE;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      ovf_r       <= 1'b0;
      dzero_r     <= 1'b0;
      nzero_r     <= 1'b0;
      op_r        <= mfa_pkg::OP_ADD;
      uop_r       <= mfa_pkg::U_FIN;
    end else begin
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;

      if (cmd.load) begin
        op_r    <= mfa_pkg::op_t'(in_operation);
        ovf_r   <= 1'b0;
        dzero_r <= 1'b0;
        nzero_r <= 1'b0;
        aw_r    <= {{(VW-W){in_a_whole[W-1]}}, in_a_whole};
        an_r    <= {{(VW-W){in_a_num[W-1]}}, in_a_num};
        ad_r    <= {{(VW-W+1){1'b0}}, in_a_den};
        bw_r    <= {{(VW-W){in_b_whole[W-1]}}, in_b_whole};
        bn_r    <= {{(VW-W){in_b_num[W-1]}}, in_b_num};
        bd_r    <= {{(VW-W+1){1'b0}}, in_b_den};
      end

      if (cmd.start) begin
        uop_r <= cmd.uop;
        case (cmd.uop)
          mfa_pkg::U_AV, mfa_pkg::U_BV, mfa_pkg::U_X, mfa_pkg::U_Y, mfa_pkg::U_DD,
          mfa_pkg::U_NMUL, mfa_pkg::U_DDIV: begin
            eng_r     <= E_MUL;
            mul_acc_r <= '0;
            mul_mc_r  <= {1'b0, mfa_pkg::mag(sel_a)};
            mul_mp_r  <= mfa_pkg::mag(sel_b);
            mul_neg_r <= sel_a[VW-1] ^ sel_b[VW-1];
          end
          mfa_pkg::U_QDIV, mfa_pkg::U_RDIV, mfa_pkg::U_DRED, mfa_pkg::U_TRUNC: begin
            eng_r <= E_DIV;
            dv_r  <= dvd_sel;
            ds_r  <= dvs_sel;
            drm_r <= '0;
            dq_r  <= '0;
            cnt_r <= CW'(MW);
          end
          mfa_pkg::U_GCD: begin
            eng_r <= E_GCD;
            gu_r  <= mfa_pkg::mag(n_r);
            gv_r  <= d_r[MW-1:0];
            gk_r  <= '0;
          end
          mfa_pkg::U_ADDS: begin
            n_r    <= adds[VW-1:0];
            ovf_r  <= ovf_r || !mfa_pkg::fits(adds);
            done_r <= 1'b1;
          end
          mfa_pkg::U_NEG: begin
            n_r    <= ~av_r + 1'b1;
            d_r    <= ad_r;
            done_r <= 1'b1;
          end
          mfa_pkg::U_NORM: begin
            if (d_r[VW-1]) begin
              n_r <= ~n_r + 1'b1;
              d_r <= ~d_r + 1'b1;
            end
            dzero_r <= (d_r == '0);
            nzero_r <= (n_r == '0);
            done_r  <= 1'b1;
          end
          default: begin
            res_whole_r <= fin_whole;
            res_num_r   <= fin_num;
            res_den_r   <= fin_den;
            order_r     <= fin_ord;
            error_r     <= fin_err;
            out_valid_r <= 1'b1;
            done_r      <= 1'b1;
          end
        endcase
      end

      case (eng_r)
        E_MUL: begin
          if (mul_mp_r == '0) begin
            case (uop_r)
              mfa_pkg::U_AV:                   av_r <= mul_fin[VW-1:0];
              mfa_pkg::U_BV:                   bv_r <= mul_fin[VW-1:0];
              mfa_pkg::U_X, mfa_pkg::U_NMUL:   x_r  <= mul_fin[VW-1:0];
              mfa_pkg::U_Y:                    y_r  <= mul_fin[VW-1:0];
              default:                         d_r  <= mul_fin[VW-1:0];
            endcase
            ovf_r  <= ovf_r || !mfa_pkg::fits(mul_fin);
            done_r <= 1'b1;
            eng_r  <= E_IDLE;
          end else begin
            if (mul_mp_r[0]) begin
              mul_acc_r <= mul_sum[MW-1:0];
            end
            mul_mc_r <= mul_mc_sh;
            mul_mp_r <= mul_mp_sh;
            if (mul_step_ovf) begin
              ovf_r  <= 1'b1;
              done_r <= 1'b1;
              eng_r  <= E_IDLE;
            end
          end
        end
        E_DIV: begin
          drm_r <= div_rm_nxt;
          dq_r  <= div_q_nxt;
          dv_r  <= {dv_r[MW-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            case (uop_r)
              mfa_pkg::U_QDIV: begin
                q_r  <= div_q_nxt;
                rm_r <= div_rm_nxt;
              end
              mfa_pkg::U_RDIV: rr_r <= div_q_nxt;
              mfa_pkg::U_DRED: dr_r <= div_q_nxt;
              default:         q_r  <= div_q_nxt;
            endcase
            done_r <= 1'b1;
            eng_r  <= E_IDLE;
          end
        end
        E_GCD: begin
          if (!gu_r[0] && !gv_r[0]) begin
            gu_r <= gu_r >> 1;
            gv_r <= gv_r >> 1;
            gk_r <= gk_r + 1'b1;
          end else if (!gu_r[0]) begin
            gu_r <= gu_r >> 1;
          end else if (!gv_r[0]) begin
            gv_r <= gv_r >> 1;
          end else if (gu_r == gv_r) begin
            g_r    <= gu_r << gk_r;
            done_r <= 1'b1;
            eng_r  <= E_IDLE;
          end else if (gu_r > gv_r) begin
            gu_r <= gu_r - gv_r;
          end else begin
            gv_r <= gv_r - gu_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts.op     = op_r;
    sts.done   = done_r;
    sts.ovf    = ovf_r;
    sts.dzero  = dzero_r;
    sts.nzero  = nzero_r;
    sts.adzero = (ad_r == '0);
  end

  assign out_valid     = out_valid_r;
  assign out_res_whole = res_whole_r;
  assign out_res_num   = res_num_r;
  assign out_res_den   = res_den_r;
  assign out_order     = order_r;
  assign out_error     = error_r;

endmodule
`default_nettype wire

// File: hw/rtl/mixed_fraction_alu.sv
// Sequence: a fraction result runs micro-operations on the serial multiplier, a binary
// GCD and three restoring divisions. Compare and truncate are shorter, and an unused
// operation code goes from the operand values straight to the result.
// Throughput: one item at a time; busy stays high until out_valid has been shown.
// Reset: synchronous active-low rst_n returns the sequencer to idle, no result pending.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module mixed_fraction_alu #(
  parameter int OPERAND_WIDTH = mfa_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [2:0]               in_operation,
  input  wire logic [OPERAND_WIDTH-1:0] in_a_whole,
  input  wire logic [OPERAND_WIDTH-1:0] in_a_num,
  input  wire logic [OPERAND_WIDTH-2:0] in_a_den,
  input  wire logic [OPERAND_WIDTH-1:0] in_b_whole,
  input  wire logic [OPERAND_WIDTH-1:0] in_b_num,
  input  wire logic [OPERAND_WIDTH-2:0] in_b_den,
  output logic                          out_valid,
  output logic [mfa_pkg::RW-1:0]        out_res_whole,
  output logic [mfa_pkg::RW-1:0]        out_res_num,
  output logic [mfa_pkg::DW-1:0]        out_res_den,
  output logic [1:0]                    out_order,
  output logic                          out_error
);

  mfa_pkg::cmd_t cmd;
  mfa_pkg::sts_t sts;

  mfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  mfa_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_operation  (in_operation),
    .in_a_whole    (in_a_whole),
    .in_a_num      (in_a_num),
    .in_a_den      (in_a_den),
    .in_b_whole    (in_b_whole),
    .in_b_num      (in_b_num),
    .in_b_den      (in_b_den),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_res_whole (out_res_whole),
    .out_res_num   (out_res_num),
    .out_res_den   (out_res_den),
    .out_order     (out_order),
    .out_error     (out_error)
  );

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside a transfer");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> (out_res_whole == '0 && out_res_num == '0 &&
      out_res_den == mfa_pkg::DW'(1) && out_order == mfa_pkg::ORD_LESS))
    else $error("error result carries data");

endmodule
`default_nettype wire

// File: dv/tb_mixed_fraction_alu.sv
// Testbench for mixed_fraction_alu: directed table then random operations, each result
// checked field by field against an in-bench rational predictor or a row's written result.
// Depends on mfa_pkg and the mixed_fraction_alu RTL.
`default_nettype none
module tb_mixed_fraction_alu;

  localparam int OW = 16;
  localparam longint I64_TOP = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [2:0]    op;
    logic [OW-1:0] aw, an;
    logic [OW-2:0] ad;
    logic [OW-1:0] bw, bn;
    logic [OW-2:0] bd;
  } operands_t;

  typedef struct {
    logic [31:0] whole;
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  ord;
    logic        err;
  } fraction_t;

  typedef struct {
    operands_t opd;
    bit        typed;
    fraction_t res;
  } row_t;

  logic clk, rst_n, start;
  logic busy, out_valid;
  logic [2:0] in_operation;
  logic [OW-1:0] in_a_whole, in_a_num, in_b_whole, in_b_num;
  logic [OW-2:0] in_a_den, in_b_den;
  logic [31:0] out_res_whole, out_res_num;
  logic [30:0] out_res_den;
  logic [1:0] out_order;
  logic out_error;

  fraction_t pending_results[$];
  int errors;
  longint cycles;
  int send_gap_pct;
  operands_t tb_item;
  row_t typed_q[$];

  mixed_fraction_alu #(.OPERAND_WIDTH(OW)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_a_whole(in_a_whole), .in_a_num(in_a_num),
    .in_a_den(in_a_den), .in_b_whole(in_b_whole), .in_b_num(in_b_num),
    .in_b_den(in_b_den), .out_valid(out_valid), .out_res_whole(out_res_whole),
    .out_res_num(out_res_num), .out_res_den(out_res_den), .out_order(out_order),
    .out_error(out_error)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint umag(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint sat_mul(longint a, longint b, inout bit ovf);
    longint ua, ub;
    ua = umag(a);
    ub = umag(b);
    if (ua != 0 && ub > I64_TOP / ua) begin
      ovf = 1'b1;
      return 0;
    end
    return ((a < 0) != (b < 0)) ? -(ua * ub) : ua * ub;
  endfunction

  function automatic longint sat_add(longint a, longint b, inout bit ovf);
    if ((b > 0 && a > I64_TOP - b) || (b < 0 && a < -I64_TOP - b)) begin
      ovf = 1'b1;
      return 0;
    end
    return a + b;
  endfunction

  function automatic fraction_t predict_fraction(operands_t o);
    fraction_t r;
    bit ovf;
    longint av, bv, n, d, x, y, g, p, q, t, w, rm;
    r = '{whole: 32'd0, num: 32'd0, den: 31'd1, ord: mfa_pkg::ORD_LESS, err: 1'b0};
    ovf = 0;
    n = 0;
    d = 1;
    av = sat_add(sat_mul(longint'($signed(o.aw)), longint'(o.ad), ovf),
                 longint'($signed(o.an)), ovf);
    bv = sat_add(sat_mul(longint'($signed(o.bw)), longint'(o.bd), ovf),
                 longint'($signed(o.bn)), ovf);
    case (o.op)
      mfa_pkg::OP_ADD, mfa_pkg::OP_SUB: begin
        x = sat_mul(av, longint'(o.bd), ovf);
        y = sat_mul(bv, longint'(o.ad), ovf);
        n = sat_add(x, o.op == mfa_pkg::OP_ADD ? y : -y, ovf);
        d = sat_mul(longint'(o.ad), longint'(o.bd), ovf);
      end
      mfa_pkg::OP_MUL: begin
        n = sat_mul(av, bv, ovf);
        d = sat_mul(longint'(o.ad), longint'(o.bd), ovf);
      end
      mfa_pkg::OP_DIV: begin
        n = sat_mul(av, longint'(o.bd), ovf);
        d = sat_mul(longint'(o.ad), bv, ovf);
      end
      mfa_pkg::OP_NEG: begin
        n = -av;
        d = longint'(o.ad);
      end
      mfa_pkg::OP_CMP: begin
        x = sat_mul(av, longint'(o.bd), ovf);
        y = sat_mul(bv, longint'(o.ad), ovf);
        if (ovf) r.err = 1'b1;
        else r.ord = x < y ? mfa_pkg::ORD_LESS :
                     (x > y ? mfa_pkg::ORD_GREATER : mfa_pkg::ORD_EQUAL);
        return r;
      end
      mfa_pkg::OP_TRUNC: begin
        if (ovf || o.ad == 0) begin
          r.err = 1'b1;
          return r;
        end
        x = av / longint'(o.ad);
        if (x < -64'sh8000_0000 || x > 64'sh7FFF_FFFF) r.err = 1'b1;
        else r.whole = x[31:0];
        return r;
      end
      default: begin
        r.err = 1'b1;
        return r;
      end
    endcase
    if (ovf || d == 0) begin
      r.err = 1'b1;
      return r;
    end
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    if (n == 0) d = 1;
    else begin
      p = umag(n);
      q = d;
      while (q != 0) begin
        t = p % q;
        p = q;
        q = t;
      end
      g = p;
      n = n / g;
      d = d / g;
    end
    w = n / d;
    rm = n % d;
    if (w < -64'sh8000_0000 || w > 64'sh7FFF_FFFF || d > 64'sh7FFF_FFFF) begin
      r.err = 1'b1;
      return r;
    end
    r.whole = w[31:0];
    r.num = rm[31:0];
    r.den = d[30:0];
    return r;
  endfunction

  function automatic logic [OW-1:0] pick_signed();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(0, 20)) - 10);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [OW-2:0] pick_den();
    case ($urandom_range(0, 5))
      0: return 15'h7FFF;
      1: return 15'd1;
      2: return 15'($urandom_range(1, 12));
      default: return 15'($urandom_range(1, 32767));
    endcase
  endfunction

  // called at a falling edge; busy is stable there, so start is held for one cycle
  task automatic send_item(operands_t o);
    while ($urandom_range(0, 99) < send_gap_pct) @(negedge clk);
    while (busy) @(negedge clk);
    in_operation <= o.op;
    in_a_whole <= o.aw;
    in_a_num <= o.an;
    in_a_den <= o.ad;
    in_b_whole <= o.bw;
    in_b_num <= o.bn;
    in_b_den <= o.bd;
    start <= 1'b1;
    @(negedge clk);
    start <= 1'b0;
  endtask

  always_comb tb_item = '{op: in_operation, aw: in_a_whole, an: in_a_num, ad: in_a_den,
                          bw: in_b_whole, bn: in_b_num, bd: in_b_den};

  always @(posedge clk) begin
    fraction_t e;
    cycles <= cycles + 1;
    if (rst_n && start && !busy) pending_results.push_back(predict_fraction(tb_item));
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer whole %0d", $time, $signed(out_res_whole));
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (typed_q.size() != 0) begin
          if (typed_q[0].typed) e = typed_q[0].res;
          typed_q.pop_front();
        end
        if (out_res_whole !== e.whole || out_res_num !== e.num || out_res_den !== e.den ||
            out_order !== e.ord || out_error !== e.err) begin
          $display("%0t: mismatch exp w=%0d n=%0d d=%0d o=%0d e=%0b",
                   $time, $signed(e.whole), $signed(e.num), e.den, e.ord, e.err);
          $display("%0t:          act w=%0d n=%0d d=%0d o=%0d e=%0b",
                   $time, $signed(out_res_whole), $signed(out_res_num), out_res_den,
                   out_order, out_error);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  row_t stim_table[$];
  localparam fraction_t F_ERR = '{32'd0, 32'd0, 31'd1, mfa_pkg::ORD_LESS, 1'b1};
  localparam fraction_t F_ZERO = '{32'd0, 32'd0, 31'd1, mfa_pkg::ORD_LESS, 1'b0};

  function automatic row_t mk(logic [2:0] op, int aw, int an, int ad, int bw, int bn, int bd,
                              bit typed = 0, fraction_t res = F_ZERO);
    row_t r;
    r.opd = '{op, 16'(aw), 16'(an), 15'(ad), 16'(bw), 16'(bn), 15'(bd)};
    r.typed = typed;
    r.res = res;
    return r;
  endfunction

  initial begin
    operands_t o;
    int phase;
    errors = 0;
    cycles = 0;
    send_gap_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    {in_operation, in_a_whole, in_a_num, in_b_whole, in_b_num} = '0;
    in_a_den = 15'd1;
    in_b_den = 15'd1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    stim_table.push_back(mk(mfa_pkg::OP_ADD, 0, 0, 1, 0, 0, 1, 1, F_ZERO));
    stim_table.push_back(mk(mfa_pkg::OP_ADD, 1, 1, 2, 2, 1, 3));
    stim_table.push_back(mk(mfa_pkg::OP_SUB, -3, -1, 4, 5, 3, 7));
    stim_table.push_back(mk(mfa_pkg::OP_MUL, -32768, -32768, 32767, -32768, -32768, 32767));
    stim_table.push_back(mk(mfa_pkg::OP_MUL, 32767, 32767, 32767, 32767, 32767, 32767));
    stim_table.push_back(mk(mfa_pkg::OP_DIV, 1, 0, 1, 0, 0, 5, 1, F_ERR));
    stim_table.push_back(mk(mfa_pkg::OP_DIV, 7, 1, 3, -2, 1, 9));
    stim_table.push_back(mk(mfa_pkg::OP_DIV, 32767, 0, 1, 0, 1, 32767));
    stim_table.push_back(mk(mfa_pkg::OP_NEG, -32768, -32768, 1, 0, 0, 1));
    stim_table.push_back(mk(mfa_pkg::OP_NEG, 2, 1, 0, 0, 0, 1, 1, F_ERR));
    stim_table.push_back(mk(mfa_pkg::OP_CMP, 1, 0, 1, 1, 0, 1, 1,
                            '{0, 0, 1, mfa_pkg::ORD_EQUAL, 0}));
    stim_table.push_back(mk(mfa_pkg::OP_CMP, -1, 0, 1, 1, 0, 1, 1,
                            '{0, 0, 1, mfa_pkg::ORD_LESS, 0}));
    stim_table.push_back(mk(mfa_pkg::OP_CMP, 3, 0, 1, -2, 0, 1, 1,
                            '{0, 0, 1, mfa_pkg::ORD_GREATER, 0}));
    stim_table.push_back(mk(mfa_pkg::OP_CMP, 3, 5, 0, 1, 1, 2));
    stim_table.push_back(mk(mfa_pkg::OP_TRUNC, -5, -1, 2, 0, 0, 1, 1,
                            '{-5, 0, 1, mfa_pkg::ORD_LESS, 0}));
    stim_table.push_back(mk(mfa_pkg::OP_TRUNC, 1, 0, 0, 0, 0, 1, 1, F_ERR));
    stim_table.push_back(mk(mfa_pkg::OP_TRUNC, 32767, 32767, 32767, 0, 0, 1));
    stim_table.push_back(mk(3'd7, 0, 0, 1, 0, 0, 1, 1, F_ERR));
    stim_table.push_back(mk(mfa_pkg::OP_ADD, 0, 5, 0, 0, 1, 1, 1, F_ERR));
    stim_table.push_back(mk(mfa_pkg::OP_SUB, 32767, -1, 32767, -32768, 1, 32766));

    foreach (stim_table[i]) begin
      typed_q.push_back(stim_table[i]);
      send_item(stim_table[i].opd);
    end

    for (phase = 0; phase < 4; phase++) begin
      send_gap_pct = (phase == 1) ? 76 : (phase == 3 ? 36 : 0);
      repeat (290) begin
        o.op = ($urandom_range(0, 49) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
        o.aw = pick_signed();
        o.an = pick_signed();
        o.ad = pick_den();
        o.bw = pick_signed();
        o.bn = pick_signed();
        o.bd = pick_den();
        if ($urandom_range(0, 3) == 0) o.bn = 16'(-($signed(o.bw) * $signed({1'b0, o.bd})));
        send_item(o);
      end
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
hw/rtl/mfa_pkg.sv
hw/rtl/mfa_ctrl.sv
hw/rtl/mfa_dp.sv
hw/rtl/mixed_fraction_alu.sv
dv/tb_mixed_fraction_alu.sv
